// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Field widths, register indexes, reset values and default sizes shared by
// the channel interfaces and the modules of the edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int PIXEL_FIELD_BITS   = 8;
	localparam int MAG_BITS           = 11;
	localparam int FRAME_WIDTH_BITS   = 11;
	localparam int FRAME_HEIGHT_BITS  = 16;
	localparam int CFG_INDEX_BITS     = 1;
	localparam int CFG_DATA_BITS      = 16;

	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_PIXEL_BITS     = 8;
	localparam int QUEUE_DEPTH        = 4;

	localparam logic [FRAME_WIDTH_BITS-1:0]  RESET_FRAME_WIDTH  = 11'd640;
	localparam logic [FRAME_HEIGHT_BITS-1:0] RESET_FRAME_HEIGHT = 16'd480;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

// ===== rtl/sem_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one grayscale pixel or one drain item.
// ----------------------------------------------------------------------------
interface sem_pixel_if;
	import sem_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [PIXEL_FIELD_BITS-1:0] pixel_value;
	logic                        is_drain;

	modport source (output valid, output pixel_value, output is_drain, input ready);
	modport sink (input valid, input pixel_value, input is_drain, output ready);
endinterface

// ===== rtl/sem_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one edge magnitude and its end of frame flag.
// ----------------------------------------------------------------------------
interface sem_result_if;
	import sem_pkg::*;

	logic                valid;
	logic                ready;
	logic [MAG_BITS-1:0] edge_magnitude;
	logic                frame_last;

	modport source (output valid, output edge_magnitude, output frame_last, input ready);
	modport sink (input valid, input edge_magnitude, input frame_last, output ready);
endinterface

// ===== rtl/sem_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface sem_cfg_if;
	import sem_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sem_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel front end
// Holds the frame size registers, the row store and the 3x3 window, tracks
// the input and output positions and queues one window per result.
// ----------------------------------------------------------------------------
module sem_front #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	sem_pixel_if.sink               pixels,
	sem_cfg_if.sink                 cfg,
	output logic                    q_push,
	output logic [8*PIXEL_BITS+1:0] q_data,
	input  logic                    q_full
);
	import sem_pkg::*;

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int LB = EW + 1;
	localparam int HB = FRAME_HEIGHT_BITS + 1;

	logic [FRAME_WIDTH_BITS-1:0]  frame_width_q;
	logic [FRAME_HEIGHT_BITS-1:0] frame_height_q;
	logic [EW-1:0]                w;
	logic [FRAME_HEIGHT_BITS-1:0] h;

	logic [CB-1:0]                in_col_q;
	logic [CB-1:0]                out_col_q;
	logic [FRAME_HEIGHT_BITS-1:0] out_row_q;
	logic [LB-1:0]                lead_q;

	logic                         accept;
	logic                         s1_adv;
	logic [CB-1:0]                col_rd;
	logic [EW-1:0]                col_nx;
	logic [CB-1:0]                in_col_nx;
	logic                         has_result;
	logic [CB-1:0]                oc;
	logic [FRAME_HEIGHT_BITS-1:0] orow;
	logic [LB-1:0]                oc_p1;
	logic [LB-1:0]                oc_p2;
	logic [HB-1:0]                orow_p1;
	logic [HB-1:0]                orow_p2;
	logic                         interior;
	logic                         last;

	logic [2*PIXEL_BITS-1:0]      line_mem [MAX_WIDTH];

	logic                         valid_s1;
	logic                         drain_s1;
	logic                         result_s1;
	logic                         interior_s1;
	logic                         last_s1;
	logic [PIXEL_BITS-1:0]        px_s1;
	logic [CB-1:0]                col_s1;
	logic [2*PIXEL_BITS-1:0]      rd_s1;
	logic                         byp_s1;
	logic [2*PIXEL_BITS-1:0]      bypd_s1;
	logic [2*PIXEL_BITS-1:0]      rows;
	logic [PIXEL_BITS-1:0]        up;
	logic [PIXEL_BITS-1:0]        mid;
	logic                         shift;

	logic [PIXEL_BITS-1:0]        win_q [3][3];
	logic [PIXEL_BITS-1:0]        nwin  [3][3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_FRAME_WIDTH;
			frame_height_q <= RESET_FRAME_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg.data[FRAME_WIDTH_BITS-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg.data[FRAME_HEIGHT_BITS-1:0];
				end
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			w = EW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w = EW'(MAX_WIDTH);
		end else begin
			w = EW'(frame_width_q);
		end
		h = (frame_height_q == '0) ? FRAME_HEIGHT_BITS'(1) : frame_height_q;
	end

	// Position bookkeeping for the item being transferred.
	always_comb begin
		col_rd     = (EW'(in_col_q) >= w) ? '0 : in_col_q;
		col_nx     = EW'(col_rd) + EW'(1);
		in_col_nx  = (col_nx >= w) ? '0 : CB'(col_nx);
		has_result = (lead_q >= LB'(w) + LB'(1));
		oc         = (EW'(out_col_q) >= w) ? '0 : out_col_q;
		orow       = (out_row_q >= h) ? '0 : out_row_q;
		oc_p1      = LB'(oc) + LB'(1);
		oc_p2      = LB'(oc) + LB'(2);
		orow_p1    = HB'(orow) + HB'(1);
		orow_p2    = HB'(orow) + HB'(2);
		interior   = (orow != '0) && (orow_p2 <= HB'(h)) && (oc != '0) && (oc_p2 <= LB'(w));
		last       = (orow_p1 == HB'(h)) && (oc_p1 == LB'(w));
	end

	assign s1_adv        = !valid_s1 || !result_s1 || !q_full;
	assign pixels.ready  = s1_adv;
	assign accept        = pixels.valid && s1_adv;
	assign q_push        = valid_s1 && result_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
		end else if (accept) begin
			if (!pixels.is_drain) begin
				in_col_q <= in_col_nx;
			end
			if (!has_result) begin
				lead_q <= lead_q + LB'(1);
			end else if (last) begin
				out_col_q <= '0;
				out_row_q <= '0;
				lead_q    <= '0;
			end else if (oc_p1 >= LB'(w)) begin
				out_col_q <= '0;
				out_row_q <= orow + FRAME_HEIGHT_BITS'(1);
			end else begin
				out_col_q <= CB'(oc_p1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= accept;
		end
	end

	assign rows  = byp_s1 ? bypd_s1 : rd_s1;
	assign up    = rows[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid   = rows[PIXEL_BITS-1:0];
	assign shift = valid_s1 && !drain_s1;

	// A read that meets the write of the previous pixel at the same column
	// takes the written data instead of the stale memory word.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= PIXEL_BITS'(32'(pixels.pixel_value));
			drain_s1    <= pixels.is_drain;
			col_s1      <= col_rd;
			result_s1   <= has_result;
			interior_s1 <= interior;
			last_s1     <= last;
			byp_s1      <= shift && (col_s1 == col_rd);
			bypd_s1     <= {mid, px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pixels.is_drain) begin
			rd_s1 <= line_mem[col_rd];
		end
		if (shift && s1_adv) begin
			line_mem[col_s1] <= {mid, px_s1};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				nwin[r][c] = win_q[r][c];
			end
		end
		if (shift) begin
			for (int r = 0; r < 3; r++) begin
				nwin[r][0] = win_q[r][1];
				nwin[r][1] = win_q[r][2];
			end
			nwin[0][2] = up;
			nwin[1][2] = mid;
			nwin[2][2] = px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift && s1_adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= nwin[r][c];
				end
			end
		end
	end

	assign q_data = {interior_s1, last_s1,
		nwin[0][0], nwin[0][1], nwin[0][2],
		nwin[1][0], nwin[1][2],
		nwin[2][0], nwin[2][1], nwin[2][2]};

endmodule

// ===== rtl/sem_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window queue
// Short first-in first-out buffer between the front end and the magnitude
// pipeline.
// ----------------------------------------------------------------------------
module sem_queue #(
	parameter int DATA_BITS = 8 * sem_pkg::DEF_PIXEL_BITS + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output logic [DATA_BITS-1:0] pop_data
);
	import sem_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] mem_q [DEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [NW-1:0]        count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == NW'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/sem_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel magnitude pipeline
// Forms both gradients, squares and sums them and takes the integer square
// root one result bit per stage. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module sem_back #(
	parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  logic [8*PIXEL_BITS+1:0] q_data,
	output logic                    q_pop,
	sem_result_if.source            results
);
	import sem_pkg::*;

	localparam int PB  = PIXEL_BITS;
	localparam int AB  = PB + 2;
	localparam int SQB = 2 * AB;
	localparam int RB  = PB + 3;
	localparam int SB  = 2 * RB;

	logic                 en;
	logic [PB-1:0]        p00, p01, p02, p10, p12, p20, p21, p22;
	logic                 interior;
	logic                 last;
	logic [AB-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [AB:0]   gx, gy;
	logic [AB-1:0]        abs_gx, abs_gy;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [AB-1:0]        abs_gx_s1, abs_gy_s1;
	logic [SQB-1:0]       sq_gx_s2, sq_gy_s2;
	logic [SB-1:0]        sum_s3;

	logic [RB-1:0]        rt_vld_q;
	logic                 rt_last_q [RB];
	logic [RB-1:0]        rt_root_q [RB];
	logic [RB:0]          rt_rem_q  [RB-1];
	logic [SB-1:0]        rt_rad_q  [RB-1];

	assign en    = !rt_vld_q[RB-1] || results.ready;
	assign q_pop = q_valid && en;

	assign p22      = q_data[1*PB-1:0*PB];
	assign p21      = q_data[2*PB-1:1*PB];
	assign p20      = q_data[3*PB-1:2*PB];
	assign p12      = q_data[4*PB-1:3*PB];
	assign p10      = q_data[5*PB-1:4*PB];
	assign p02      = q_data[6*PB-1:5*PB];
	assign p01      = q_data[7*PB-1:6*PB];
	assign p00      = q_data[8*PB-1:7*PB];
	assign last     = q_data[8*PB];
	assign interior = q_data[8*PB+1];

	always_comb begin
		gx_pos = AB'(p02) + (AB'(p12) << 1) + AB'(p22);
		gx_neg = AB'(p00) + (AB'(p10) << 1) + AB'(p20);
		gy_pos = AB'(p20) + (AB'(p21) << 1) + AB'(p22);
		gy_neg = AB'(p00) + (AB'(p01) << 1) + AB'(p02);
		gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
		gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
		abs_gx = gx[AB] ? AB'(-gx) : AB'(gx);
		abs_gy = gy[AB] ? AB'(-gy) : AB'(gy);
		if (!interior) begin
			abs_gx = '0;
			abs_gy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abs_gx_s1 <= abs_gx;
			abs_gy_s1 <= abs_gy;
			last_s1   <= last;
			sq_gx_s2  <= abs_gx_s1 * abs_gx_s1;
			sq_gy_s2  <= abs_gy_s1 * abs_gy_s1;
			last_s2   <= last_s1;
			sum_s3    <= SB'(sq_gx_s2) + SB'(sq_gy_s2);
			last_s3   <= last_s2;
		end
	end

	// Restoring square root: each stage brings down two radicand bits and
	// settles one root bit, most significant first.
	for (genvar k = 0; k < RB; k++) begin : g_root
		logic [RB:0]   rem_in;
		logic [RB-1:0] root_in;
		logic [SB-1:0] rad_in;
		logic          vld_in;
		logic          last_in;
		logic [RB+2:0] cat;
		logic [RB+2:0] trial;
		logic          fit;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = sum_s3;
			assign vld_in  = valid_s3;
			assign last_in = last_s3;
		end else begin : g_next
			assign rem_in  = rt_rem_q[k-1];
			assign root_in = rt_root_q[k-1];
			assign rad_in  = rt_rad_q[k-1];
			assign vld_in  = rt_vld_q[k-1];
			assign last_in = rt_last_q[k-1];
		end

		assign cat   = {rem_in, rad_in[2*(RB-1-k)+1 -: 2]};
		assign trial = (RB+3)'({root_in, 2'b01});
		assign fit   = (cat >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_q[k] <= 1'b0;
			end else if (en) begin
				rt_vld_q[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_root_q[k] <= {root_in[RB-2:0], fit};
				rt_last_q[k] <= last_in;
			end
		end

		if (k < RB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rt_rem_q[k] <= fit ? (RB+1)'(cat - trial) : cat[RB:0];
					rt_rad_q[k] <= rad_in;
				end
			end
		end
	end

	assign results.valid          = rt_vld_q[RB-1];
	assign results.edge_magnitude = MAG_BITS'(32'(rt_root_q[RB-1]));
	assign results.frame_last     = rt_last_q[RB-1];

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streaming 3x3 Sobel gradient magnitude over a raster-order grayscale frame.
//
// Channels: pixels takes one pixel or one drain item per transfer; results
// gives one edge magnitude per transfer with frame_last on the final pixel
// of the frame; cfg writes frame_width (index 0) and frame_height (index 1)
// and is always ready. Write cfg only while the block is idle.
// The first frame_width + 1 items of a frame give no result; every later
// item gives one, for the pixel one row plus one earlier. After the last
// pixel the host sends frame_width + 1 drain items to flush the frame.
// Throughput is one item per clock while the queue has room, set by the
// single row store memory that is read and written once per pixel. A result
// passes the front end register, the queue and the magnitude pipeline stages.
// Reset clears the positions and the window and loads 640 x 480; the row
// store is not cleared. When results stalls, the magnitude pipeline holds,
// a four-entry queue fills and then pixels.ready falls.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = sem_pkg::DEF_PIXEL_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	sem_pixel_if.sink    pixels,
	sem_result_if.source results,
	sem_cfg_if.sink      cfg
);
	import sem_pkg::*;

	localparam int QB = 8 * PIXEL_BITS + 2;

	logic          q_push;
	logic [QB-1:0] q_push_data;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [QB-1:0] q_pop_data;

	sem_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.cfg    (cfg),
		.q_push (q_push),
		.q_data (q_push_data),
		.q_full (q_full)
	);

	sem_queue #(
		.DATA_BITS (QB)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_pop_data)
	);

	sem_back #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_pop_data),
		.q_pop   (q_pop),
		.results (results)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("window pushed into a full queue");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixels.ready |-> q_full)
		else $error("pixel channel stalled while the queue has room");

	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_last) |-> (results.edge_magnitude == '0))
		else $error("final pixel of a frame gave a nonzero magnitude");

endmodule
